@@ hdl/hsv2rgb_pkg.sv @@
// Shared constants, widths and types for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int CHAN_W = 8;
	localparam int REM_W = 6;
	localparam int VSC_W = 11;
	localparam int K_W = 13;
	localparam int X_W = 24;
	localparam int RECIP_W = 25;
	localparam int PROD_W = X_W + RECIP_W;

	localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_WRAP_AT = 7'd101;
	localparam logic [HUE_W-1:0] SECTOR_SPAN = 9'd60;

	// A channel is floor(v * 17 * k / 40000), with k at most 6000 (the full-scale weight).
	localparam logic [K_W-1:0] K_MAX = 13'd6000;
	localparam logic [VSC_W-1:0] V_SCALE = 11'd17;

	localparam longint unsigned DIVISOR = 64'd40000;
	localparam int RECIP_SHIFT = 40;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	typedef struct packed {
		logic ld5;
		logic ld6;
	} scale_ctl_t;

endpackage

`default_nettype wire

@@ hdl/hsv2rgb_scale.sv @@
// One channel's final two stages: weight times scaled value, then exact divide by 40000.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_scale (
	input  wire                              clk,
	input  hsv2rgb_pkg::scale_ctl_t          ctl,
	input  wire [hsv2rgb_pkg::VSC_W-1:0]     vsc,
	input  wire [hsv2rgb_pkg::K_W-1:0]       weight,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]   chan
);

	logic [hsv2rgb_pkg::X_W-1:0]    x_s5;
	logic [hsv2rgb_pkg::PROD_W-1:0] prod;
	logic [hsv2rgb_pkg::CHAN_W-1:0] q_s6;

	// The rounded-up reciprocal with a 40-bit shift is exact for every 24-bit dividend.
	assign prod = hsv2rgb_pkg::PROD_W'(x_s5) * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld5) begin
			x_s5 <= hsv2rgb_pkg::X_W'(vsc) * hsv2rgb_pkg::X_W'(weight);
		end
		if (ctl.ld6) begin
			q_s6 <= prod[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CHAN_W];
		end
	end

	assign chan = q_s6;

endmodule

`default_nettype wire

@@ hdl/hsv_to_rgb_converter_core.sv @@
// Top level of the HSV to RGB converter: six-stage pipeline with per-stage valid bits.
//
//  channel  direction  handshake            payload
//  hsv      in         hsv_valid/hsv_stall  hue[8:0], saturation[6:0], brightness[6:0]
//  rgb      out        rgb_valid/rgb_stall  red[7:0], green[7:0], blue[7:0]
//
// Each hsv transfer yields one rgb result; one item per cycle while rgb_stall is low.
// Stages: wrap, sector split, weight products, sector select, multiply, reciprocal divide.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up.
// hsv_stall rises only when all six stages hold items and the rgb side is stalled.
// Reset clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        hsv_valid,
	output logic       hsv_stall,
	input  wire  [8:0] hue,
	input  wire  [6:0] saturation,
	input  wire  [6:0] brightness,
	output logic       rgb_valid,
	input  wire        rgb_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic [hsv2rgb_pkg::HUE_W-1:0] h_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0] s_s1, v_s1;

	hsv2rgb_pkg::sector_t           sector_s2;
	logic [hsv2rgb_pkg::REM_W-1:0]  d_s2;
	logic [hsv2rgb_pkg::PCT_W-1:0]  s_s2;
	logic [hsv2rgb_pkg::VSC_W-1:0]  vsc_s2;

	hsv2rgb_pkg::sector_t           sector_s3;
	logic [hsv2rgb_pkg::K_W-1:0]    sd_s3, kmin_s3;
	logic [hsv2rgb_pkg::VSC_W-1:0]  vsc_s3;

	logic [hsv2rgb_pkg::K_W-1:0]    kr_s4, kg_s4, kb_s4;
	logic [hsv2rgb_pkg::VSC_W-1:0]  vsc_s4;

	hsv2rgb_pkg::sector_t           sector_d;
	logic [hsv2rgb_pkg::HUE_W-1:0]  base_d;
	logic [hsv2rgb_pkg::K_W-1:0]    kr_d, kg_d, kb_d, kup, kdn;
	hsv2rgb_pkg::scale_ctl_t        sc_ctl;

	// Ready chain from the output back to the input.
	assign adv6 = !vld_s6 || !rgb_stall;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign hsv_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= hsv_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// Sector split: the hue is already below 360 here.
	always_comb begin
		if (h_s1 >= 9'd300) begin
			sector_d = hsv2rgb_pkg::SECTOR_5;
			base_d = 9'd300;
		end else if (h_s1 >= 9'd240) begin
			sector_d = hsv2rgb_pkg::SECTOR_4;
			base_d = 9'd240;
		end else if (h_s1 >= 9'd180) begin
			sector_d = hsv2rgb_pkg::SECTOR_3;
			base_d = 9'd180;
		end else if (h_s1 >= 9'd120) begin
			sector_d = hsv2rgb_pkg::SECTOR_2;
			base_d = 9'd120;
		end else if (h_s1 >= hsv2rgb_pkg::SECTOR_SPAN) begin
			sector_d = hsv2rgb_pkg::SECTOR_1;
			base_d = hsv2rgb_pkg::SECTOR_SPAN;
		end else begin
			sector_d = hsv2rgb_pkg::SECTOR_0;
			base_d = 9'd0;
		end
	end

	// Rising and falling weights of the sector; the full-scale weight is K_MAX.
	assign kup = kmin_s3 + sd_s3;
	assign kdn = hsv2rgb_pkg::K_MAX - sd_s3;

	always_comb begin
		case (sector_s3)
			hsv2rgb_pkg::SECTOR_0: begin
				kr_d = hsv2rgb_pkg::K_MAX; kg_d = kup; kb_d = kmin_s3;
			end
			hsv2rgb_pkg::SECTOR_1: begin
				kr_d = kdn; kg_d = hsv2rgb_pkg::K_MAX; kb_d = kmin_s3;
			end
			hsv2rgb_pkg::SECTOR_2: begin
				kr_d = kmin_s3; kg_d = hsv2rgb_pkg::K_MAX; kb_d = kup;
			end
			hsv2rgb_pkg::SECTOR_3: begin
				kr_d = kmin_s3; kg_d = kdn; kb_d = hsv2rgb_pkg::K_MAX;
			end
			hsv2rgb_pkg::SECTOR_4: begin
				kr_d = kup; kg_d = kmin_s3; kb_d = hsv2rgb_pkg::K_MAX;
			end
			hsv2rgb_pkg::SECTOR_5: begin
				kr_d = hsv2rgb_pkg::K_MAX; kg_d = kmin_s3; kb_d = kdn;
			end
			default: begin
				kr_d = hsv2rgb_pkg::K_MAX; kg_d = kmin_s3; kb_d = kdn;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			h_s1 <= (hue >= hsv2rgb_pkg::HUE_WRAP) ? hue - hsv2rgb_pkg::HUE_WRAP : hue;
			s_s1 <= (saturation >= hsv2rgb_pkg::PCT_WRAP_AT) ?
				saturation - hsv2rgb_pkg::PCT_FULL : saturation;
			v_s1 <= (brightness >= hsv2rgb_pkg::PCT_WRAP_AT) ?
				brightness - hsv2rgb_pkg::PCT_FULL : brightness;
		end
		if (adv2) begin
			sector_s2 <= sector_d;
			d_s2 <= hsv2rgb_pkg::REM_W'(h_s1 - base_d);
			s_s2 <= s_s1;
			vsc_s2 <= hsv2rgb_pkg::VSC_W'(v_s1) * hsv2rgb_pkg::V_SCALE;
		end
		if (adv3) begin
			sector_s3 <= sector_s2;
			sd_s3 <= hsv2rgb_pkg::K_W'(s_s2) * hsv2rgb_pkg::K_W'(d_s2);
			kmin_s3 <= hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTOR_SPAN) *
				hsv2rgb_pkg::K_W'(hsv2rgb_pkg::PCT_FULL - s_s2);
			vsc_s3 <= vsc_s2;
		end
		if (adv4) begin
			kr_s4 <= kr_d;
			kg_s4 <= kg_d;
			kb_s4 <= kb_d;
			vsc_s4 <= vsc_s3;
		end
	end

	assign sc_ctl.ld5 = adv5;
	assign sc_ctl.ld6 = adv6;

	hsv2rgb_scale u_scale_r (
		.clk    (clk),
		.ctl    (sc_ctl),
		.vsc    (vsc_s4),
		.weight (kr_s4),
		.chan   (red)
	);

	hsv2rgb_scale u_scale_g (
		.clk    (clk),
		.ctl    (sc_ctl),
		.vsc    (vsc_s4),
		.weight (kg_s4),
		.chan   (green)
	);

	hsv2rgb_scale u_scale_b (
		.clk    (clk),
		.ctl    (sc_ctl),
		.vsc    (vsc_s4),
		.weight (kb_s4),
		.chan   (blue)
	);

	assign rgb_valid = vld_s6;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6))
		else $error("input stalled while the pipeline has a bubble");

	a_stage1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv1) |=> (vld_s1 && $stable(h_s1) && $stable(s_s1) && $stable(v_s1)))
		else $error("stage 1 item lost or changed while held");

	a_remainder_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && vld_s1) |-> (d_s2 < hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_SPAN)))
		else $error("hue remainder outside its sector");

	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (kr_s4 <= hsv2rgb_pkg::K_MAX && kg_s4 <= hsv2rgb_pkg::K_MAX &&
			kb_s4 <= hsv2rgb_pkg::K_MAX))
		else $error("channel weight above full scale");
`endif

endmodule

`default_nettype wire
